// ===== hw/rtl/rfc_pkg.sv =====
// rfc_pkg: shared constants, result record and crc16 byte update for the
// response frame checker; no dependencies
package rfc_pkg;

  localparam int unsigned COUNT_W   = 17;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 17;

  localparam logic [15:0] CRC_INIT  = 16'hffff;
  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [7:0]  SYNC_FIRST  = 8'h5a;
  localparam logic [7:0]  SYNC_SECOND = 8'ha5;
  localparam logic [COUNT_W-1:0] MIN_FRAME = 17'd10;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 17'h1ffff;
  localparam logic [COUNT_W-1:0] MAX_FRAME_RESET = 17'd65545;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VERSION  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEQUENCE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COMMAND  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LEN  = 2'd3;

  // frame byte offsets
  localparam logic [COUNT_W-1:0] OFS_SYNC1   = 17'd0;
  localparam logic [COUNT_W-1:0] OFS_SYNC2   = 17'd1;
  localparam logic [COUNT_W-1:0] OFS_VERSION = 17'd2;
  localparam logic [COUNT_W-1:0] OFS_SEQ     = 17'd3;
  localparam logic [COUNT_W-1:0] OFS_CMD     = 17'd4;
  localparam logic [COUNT_W-1:0] OFS_STATUS  = 17'd5;
  localparam logic [COUNT_W-1:0] OFS_LEN_HI  = 17'd6;
  localparam logic [COUNT_W-1:0] OFS_LEN_LO  = 17'd7;
  localparam logic [COUNT_W-1:0] OFS_PAYLOAD = 17'd8;

  // error flag bits
  localparam int unsigned FLAG_HEADER = 0;
  localparam int unsigned FLAG_SEQ    = 1;
  localparam int unsigned FLAG_LEN    = 2;

  localparam logic RESULT_PAYLOAD = 1'b0;
  localparam logic RESULT_VERDICT = 1'b1;

  localparam logic [2:0] VERDICT_OK     = 3'd0;
  localparam logic [2:0] VERDICT_SHORT  = 3'd1;
  localparam logic [2:0] VERDICT_FORMAT = 3'd2;
  localparam logic [2:0] VERDICT_SEQ    = 3'd3;
  localparam logic [2:0] VERDICT_CRC    = 3'd4;
  localparam logic [2:0] VERDICT_STATUS = 3'd5;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload;
    logic [2:0]  verdict;
    logic [7:0]  status;
    logic [15:0] length;
  } result_t;

  // crc16-ccitt, msb first, one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/response_frame_checker_crc16.sv =====
// a result is registered into the output slot, or into the skid slot while the output is stalled
// throughput: one byte per cycle while in_stall is low; the crc update is one unrolled byte step
// in_stall rises only while the skid register holds a second result
// rst (synchronous) clears frame state, config to defaults, both result slots
// response frame checker: header checks, payload forwarding, crc16 verdict
// depends on rfc_pkg
module response_frame_checker_crc16
  import rfc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [7:0]            data_byte,
  input  logic                  end_of_frame,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  result_kind,
  output logic [7:0]            payload_byte,
  output logic [2:0]            verdict,
  output logic [7:0]            device_status,
  output logic [15:0]           length_field
);

  logic [7:0]         protocol_version;
  logic [7:0]         seq_target;
  logic [7:0]         expected_command;
  logic [COUNT_W-1:0] max_frame_length;

  logic [COUNT_W-1:0] byte_count, byte_count_next;
  logic [15:0]        running_crc, running_crc_next;
  logic [15:0]        trailer_crc, trailer_crc_next;
  logic [15:0]        header_length, header_length_next;
  logic [7:0]         status_seen, status_seen_next;
  logic [2:0]         error_flags, error_flags_next;

  logic               skid_valid;
  result_t            out_data, skid_data, res;
  logic               accept, forward, produce, out_taken;
  logic [COUNT_W-1:0] crc_at, crc_at_lo, legal_total, len_total;
  logic [2:0]         verdict_code;

  assign accept    = in_valid && !in_stall;
  assign out_taken = out_valid && !out_stall;
  assign in_stall  = skid_valid;

  assign crc_at    = OFS_PAYLOAD + COUNT_W'(header_length);
  assign crc_at_lo = crc_at + 17'd1;

  always_comb begin
    running_crc_next   = running_crc;
    trailer_crc_next   = trailer_crc;
    header_length_next = header_length;
    status_seen_next   = status_seen;
    error_flags_next   = error_flags;
    forward            = 1'b0;
    len_total          = '0;
    priority if (byte_count == OFS_SYNC1) begin
      if (data_byte != SYNC_FIRST) error_flags_next[FLAG_HEADER] = 1'b1;
    end else if (byte_count == OFS_SYNC2) begin
      if (data_byte != SYNC_SECOND) error_flags_next[FLAG_HEADER] = 1'b1;
    end else if (byte_count < OFS_PAYLOAD) begin
      running_crc_next = crc16_byte(running_crc, data_byte);
      if (byte_count == OFS_VERSION && data_byte != protocol_version)
        error_flags_next[FLAG_HEADER] = 1'b1;
      if (byte_count == OFS_SEQ && data_byte != seq_target)
        error_flags_next[FLAG_SEQ] = 1'b1;
      if (byte_count == OFS_CMD && data_byte != expected_command)
        error_flags_next[FLAG_HEADER] = 1'b1;
      if (byte_count == OFS_STATUS) status_seen_next = data_byte;
      if (byte_count == OFS_LEN_HI) header_length_next = {data_byte, 8'h00};
      if (byte_count == OFS_LEN_LO) begin
        header_length_next = {header_length[15:8], data_byte};
        len_total = MIN_FRAME + COUNT_W'(header_length_next);
        if (len_total > max_frame_length) error_flags_next[FLAG_LEN] = 1'b1;
      end
    end else if (byte_count < crc_at) begin
      running_crc_next = crc16_byte(running_crc, data_byte);
      forward = 1'b1;
    end else if (byte_count == crc_at) begin
      trailer_crc_next = {data_byte, 8'h00};
    end else if (byte_count == crc_at_lo) begin
      trailer_crc_next = {trailer_crc[15:8], data_byte};
    end
  end

  // saturating count including this byte
  assign byte_count_next = (byte_count == COUNT_MAX) ? byte_count : byte_count + 17'd1;
  assign legal_total     = MIN_FRAME + COUNT_W'(header_length_next);

  always_comb begin
    priority if (byte_count_next < MIN_FRAME)    verdict_code = VERDICT_SHORT;
    else if (error_flags_next[FLAG_HEADER])      verdict_code = VERDICT_FORMAT;
    else if (error_flags_next[FLAG_SEQ])         verdict_code = VERDICT_SEQ;
    else if (error_flags_next[FLAG_LEN] || byte_count_next != legal_total)
                                                 verdict_code = VERDICT_FORMAT;
    else if (running_crc_next != trailer_crc_next) verdict_code = VERDICT_CRC;
    else if (status_seen_next != 8'h00)          verdict_code = VERDICT_STATUS;
    else                                         verdict_code = VERDICT_OK;
  end

  always_comb begin
    res = '0;
    if (end_of_frame) begin
      res.kind    = RESULT_VERDICT;
      res.verdict = verdict_code;
      res.status  = status_seen_next;
      res.length  = header_length_next;
    end else begin
      res.kind    = RESULT_PAYLOAD;
      res.payload = data_byte;
    end
  end

  assign produce = accept && (end_of_frame || forward);

  always_ff @(posedge clk) begin
    if (rst) begin
      protocol_version  <= '0;
      seq_target        <= '0;
      expected_command  <= '0;
      max_frame_length  <= MAX_FRAME_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_VERSION:  protocol_version  <= cfg_data[7:0];
        REG_SEQUENCE: seq_target        <= cfg_data[7:0];
        REG_COMMAND:  expected_command  <= cfg_data[7:0];
        REG_MAX_LEN:  max_frame_length  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (accept && end_of_frame)) begin
      byte_count    <= '0;
      running_crc   <= CRC_INIT;
      trailer_crc   <= '0;
      header_length <= '0;
      status_seen   <= '0;
      error_flags   <= '0;
    end else if (accept) begin
      byte_count    <= byte_count_next;
      running_crc   <= running_crc_next;
      trailer_crc   <= trailer_crc_next;
      header_length <= header_length_next;
      status_seen   <= status_seen_next;
      error_flags   <= error_flags_next;
    end
  end

  // output register plus skid slot; input is never taken while skid is full
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_taken) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= produce;
        if (produce) out_data <= res;
      end
    end else if (produce) begin
      skid_valid <= 1'b1;
      skid_data  <= res;
    end
  end

  assign result_kind    = out_data.kind;
  assign payload_byte   = out_data.payload;
  assign verdict        = out_data.verdict;
  assign device_status  = out_data.status;
  assign length_field   = out_data.length;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid slot full while output slot empty");

  a_frame_clears: assert property (@(posedge clk) disable iff (rst)
    accept && end_of_frame |=> byte_count == '0 && error_flags == '0)
    else $error("frame state not cleared after final byte");

  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && result_kind == RESULT_PAYLOAD |->
      verdict == VERDICT_OK && length_field == 16'h0000 && device_status == 8'h00)
    else $error("forwarded byte carries verdict fields");

  a_crc_idle: assert property (@(posedge clk) disable iff (rst)
    byte_count <= OFS_VERSION |-> running_crc == CRC_INIT)
    else $error("crc moved before version byte");
`endif

endmodule

// ===== tb/rfc_frame_monitor.sv =====
// rfc_frame_monitor: watches the response frame checker ports, predicts each
// transaction's outcome and compares it; also holds the crc16 helper package
// depends on rfc_pkg
`timescale 1ns / 1ps

package rfc_tb_crc_pkg;

  localparam logic [15:0] CCITT_SEED = 16'hffff;
  localparam logic [15:0] CCITT_POLY = 16'h1021;

  // bit-serial crc16-ccitt, msb of the byte first
  function automatic logic [15:0] crc16_ccitt_next(input logic [15:0] crc,
                                                   input logic [7:0] b);
    logic [15:0] r;
    logic fb;
    r = crc;
    for (int i = 7; i >= 0; i--) begin
      fb = r[15] ^ b[i];
      r = {r[14:0], 1'b0};
      if (fb) begin
        r = r ^ CCITT_POLY;
      end
    end
    return r;
  endfunction

endpackage

module rfc_frame_monitor
  import rfc_pkg::*;
  import rfc_tb_crc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [7:0]            data_byte,
  input  logic                  end_of_frame,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic                  result_kind,
  input  logic [7:0]            payload_byte,
  input  logic [2:0]            verdict,
  input  logic [7:0]            device_status,
  input  logic [15:0]           length_field,
  output int                    errors,
  output int                    pending,
  output int                    n_forwarded,
  output int                    n_verdicts,
  output int                    n_ok
);

  // register copies
  logic [7:0]         cfg_version;
  logic [7:0]         cfg_sequence;
  logic [7:0]         cfg_command;
  logic [COUNT_W-1:0] cfg_max_len;

  // frame state
  logic [COUNT_W-1:0] frame_count;
  logic [15:0]        frame_crc;
  logic [15:0]        sent_crc;
  logic [15:0]        hdr_len;
  logic [7:0]         seen_status;
  logic               flag_header;
  logic               flag_seq;
  logic               flag_len;

  result_t awaited_results[$];

  initial begin
    errors = 0;
    pending = 0;
    n_forwarded = 0;
    n_verdicts = 0;
    n_ok = 0;
  end

  task automatic clear_frame();
    frame_count = '0;
    frame_crc = CCITT_SEED;
    sent_crc = '0;
    hdr_len = '0;
    seen_status = '0;
    flag_header = 1'b0;
    flag_seq = 1'b0;
    flag_len = 1'b0;
  endtask

  task automatic absorb_frame_byte(input logic [7:0] b, input logic last);
    logic [COUNT_W-1:0] crc_pos;
    logic forward;
    result_t res;
    crc_pos = OFS_PAYLOAD + {1'b0, hdr_len};
    forward = 1'b0;
    if (frame_count == OFS_SYNC1) begin
      if (b != SYNC_FIRST) flag_header = 1'b1;
    end else if (frame_count == OFS_SYNC2) begin
      if (b != SYNC_SECOND) flag_header = 1'b1;
    end else if (frame_count < OFS_PAYLOAD) begin
      frame_crc = crc16_ccitt_next(frame_crc, b);
      case (frame_count)
        OFS_VERSION: if (b != cfg_version) flag_header = 1'b1;
        OFS_SEQ:     if (b != cfg_sequence) flag_seq = 1'b1;
        OFS_CMD:     if (b != cfg_command) flag_header = 1'b1;
        OFS_STATUS:  seen_status = b;
        OFS_LEN_HI:  hdr_len = {b, 8'h00};
        OFS_LEN_LO: begin
          hdr_len[7:0] = b;
          if ({1'b0, hdr_len} + MIN_FRAME > cfg_max_len) flag_len = 1'b1;
        end
        default: ;
      endcase
    end else if (frame_count < crc_pos) begin
      frame_crc = crc16_ccitt_next(frame_crc, b);
      forward = 1'b1;
    end else if (frame_count == crc_pos) begin
      sent_crc = {b, 8'h00};
    end else if (frame_count == crc_pos + 1'b1) begin
      sent_crc[7:0] = b;
    end

    if (frame_count != COUNT_MAX) frame_count++;

    res = '0;
    if (!last) begin
      if (forward) begin
        res.kind = RESULT_PAYLOAD;
        res.payload = b;
        awaited_results.push_back(res);
      end
    end else begin
      res.kind = RESULT_VERDICT;
      if (frame_count < MIN_FRAME) res.verdict = VERDICT_SHORT;
      else if (flag_header) res.verdict = VERDICT_FORMAT;
      else if (flag_seq) res.verdict = VERDICT_SEQ;
      // a saturated count never equals a legal length
      else if (flag_len || frame_count != MIN_FRAME + {1'b0, hdr_len})
        res.verdict = VERDICT_FORMAT;
      else if (frame_crc != sent_crc) res.verdict = VERDICT_CRC;
      else if (seen_status != 8'h00) res.verdict = VERDICT_STATUS;
      else res.verdict = VERDICT_OK;
      res.status = seen_status;
      res.length = hdr_len;
      awaited_results.push_back(res);
      clear_frame();
    end
  endtask

  task automatic check_field(input string field, input logic [15:0] exp_v,
                             input logic [15:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, exp_v, act_v);
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      cfg_version = 8'h00;
      cfg_sequence = 8'h00;
      cfg_command = 8'h00;
      cfg_max_len = MAX_FRAME_RESET;
      clear_frame();
      awaited_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, actual kind %0h payload %0h verdict %0h",
                   $time, result_kind, payload_byte, verdict);
        end else begin
          want = awaited_results.pop_front();
          check_field("result_kind", 16'(want.kind), 16'(result_kind));
          check_field("payload_byte", 16'(want.payload), 16'(payload_byte));
          check_field("verdict", 16'(want.verdict), 16'(verdict));
          check_field("device_status", 16'(want.status), 16'(device_status));
          check_field("length_field", want.length, length_field);
          if (want.kind == RESULT_PAYLOAD) begin
            n_forwarded++;
          end else begin
            n_verdicts++;
            if (want.verdict == VERDICT_OK) n_ok++;
          end
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_VERSION:  cfg_version = cfg_data[7:0];
          REG_SEQUENCE: cfg_sequence = cfg_data[7:0];
          REG_COMMAND:  cfg_command = cfg_data[7:0];
          REG_MAX_LEN:  cfg_max_len = cfg_data[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) absorb_frame_byte(data_byte, end_of_frame);
    end
    pending = awaited_results.size();
  end

endmodule

// ===== tb/tb_response_frame_checker_crc16.sv =====
// tb_response_frame_checker_crc16: drives directed and random response frames
// through the checker under several register settings and reports the verdict
// depends on rfc_pkg, rfc_tb_crc_pkg, rfc_frame_monitor
`timescale 1ns / 1ps

module tb_response_frame_checker_crc16;
  import rfc_pkg::*;
  import rfc_tb_crc_pkg::*;

  localparam int LIMIT_CYCLES = 1000000;
  localparam int PHASE_BYTES = 150;

  typedef enum int {
    FK_GOOD, FK_STATUS, FK_BAD_SYNC, FK_BAD_VERSION, FK_BAD_COMMAND,
    FK_BAD_SEQUENCE, FK_BAD_CRC, FK_TRUNCATED, FK_TRAILING, FK_OVER_MAX,
    FK_SHORT, FK_NOISE
  } frame_kind_e;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_VERSION;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            data_byte = 8'h00;
  logic                  end_of_frame = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  result_kind;
  logic [7:0]            payload_byte;
  logic [2:0]            verdict;
  logic [7:0]            device_status;
  logic [15:0]           length_field;

  int errors;
  int pending;
  int n_forwarded;
  int n_verdicts;
  int n_ok;

  logic               idle_on = 1'b0;
  int                 stall_left = 0;
  int                 cycle_count = 0;
  int                 bytes_sent = 0;
  int                 frames_sent = 0;
  logic [7:0]         frame_bytes[$];
  logic [7:0]         ver_now, seq_now, cmd_now;
  logic [COUNT_W-1:0] max_now;

  response_frame_checker_crc16 i_dut (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .end_of_frame   (end_of_frame),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_kind    (result_kind),
    .payload_byte   (payload_byte),
    .verdict        (verdict),
    .device_status  (device_status),
    .length_field   (length_field)
  );

  rfc_frame_monitor i_frame_monitor (
    .clk            (clk),
    .rst            (rst),
    .cfg_write      (cfg_write),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .data_byte      (data_byte),
    .end_of_frame   (end_of_frame),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_kind    (result_kind),
    .payload_byte   (payload_byte),
    .verdict        (verdict),
    .device_status  (device_status),
    .length_field   (length_field),
    .errors         (errors),
    .pending        (pending),
    .n_forwarded    (n_forwarded),
    .n_verdicts     (n_verdicts),
    .n_ok           (n_ok)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("%0t: run limit of %0d cycles reached", $time, LIMIT_CYCLES);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // receiver back-pressure in random bursts
  always @(posedge clk) begin
    if (rst || !idle_on) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic logic [7:0] flip_mask();
    return 8'($urandom_range(1, 255));
  endfunction

  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    end_of_frame <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    frames_sent++;
  endtask

  // drop valid and wait until every outstanding result has been seen
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  task automatic program_all(input logic [7:0] v, s, c, input logic [COUNT_W-1:0] m);
    write_reg(REG_VERSION, CFG_DATA_W'(v));
    write_reg(REG_SEQUENCE, CFG_DATA_W'(s));
    write_reg(REG_COMMAND, CFG_DATA_W'(c));
    write_reg(REG_MAX_LEN, m);
    cfg_write <= 1'b0;
    ver_now = v;
    seq_now = s;
    cmd_now = c;
    max_now = m;
  endtask

  // append the big-endian crc over version through payload
  task automatic seal_frame();
    logic [15:0] crc;
    crc = CCITT_SEED;
    for (int i = 2; i < frame_bytes.size(); i++) crc = crc16_ccitt_next(crc, frame_bytes[i]);
    frame_bytes.push_back(crc[15:8]);
    frame_bytes.push_back(crc[7:0]);
  endtask

  task automatic build_frame();
    frame_kind_e kind;
    int pick, lo, n;
    logic [15:0] len;
    logic [7:0] ver, seq, cmd, status;
    pick = $urandom_range(0, 99);
    if (pick < 30) kind = FK_GOOD;
    else if (pick < 45) kind = FK_STATUS;
    else if (pick < 50) kind = FK_BAD_SYNC;
    else if (pick < 55) kind = FK_BAD_VERSION;
    else if (pick < 60) kind = FK_BAD_COMMAND;
    else if (pick < 67) kind = FK_BAD_SEQUENCE;
    else if (pick < 74) kind = FK_BAD_CRC;
    else if (pick < 80) kind = FK_TRUNCATED;
    else if (pick < 85) kind = FK_TRAILING;
    else if (pick < 90) kind = FK_OVER_MAX;
    else if (pick < 95) kind = FK_SHORT;
    else kind = FK_NOISE;

    ver = ver_now;
    seq = seq_now;
    cmd = cmd_now;
    status = (kind == FK_STATUS) ? 8'($urandom_range(1, 255)) : 8'h00;
    len = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(9, 40)) : 16'($urandom_range(0, 8));
    case (kind)
      FK_BAD_VERSION:  ver ^= flip_mask();
      FK_BAD_COMMAND:  cmd ^= flip_mask();
      FK_BAD_SEQUENCE: seq ^= flip_mask();
      FK_OVER_MAX: begin
        lo = int'(max_now) - 9;
        if (lo < 0) lo = 0;
        len = (lo > 65535) ? 16'hffff : 16'(lo + $urandom_range(0, 65535 - lo));
      end
      default: ;
    endcase

    frame_bytes = {SYNC_FIRST, SYNC_SECOND, ver, seq, cmd, status, len[15:8], len[7:0]};
    // an oversized length is cut short after at most six payload bytes
    n = (kind == FK_OVER_MAX) ? $urandom_range(0, 6) : int'(len);
    if (n > int'(len)) n = int'(len);
    repeat (n) frame_bytes.push_back(8'($urandom));
    seal_frame();

    case (kind)
      FK_BAD_SYNC: frame_bytes[$urandom_range(0, 1)] ^= flip_mask();
      FK_BAD_CRC:  frame_bytes[frame_bytes.size() - 1 - $urandom_range(0, 1)] ^= flip_mask();
      FK_TRUNCATED: begin
        n = $urandom_range(1, frame_bytes.size() - 1);
        repeat (n) void'(frame_bytes.pop_back());
      end
      FK_TRAILING: repeat ($urandom_range(1, 4)) frame_bytes.push_back(8'($urandom));
      FK_SHORT: begin
        n = $urandom_range(1, 9);
        while (frame_bytes.size() > n) void'(frame_bytes.pop_back());
      end
      FK_NOISE: begin
        frame_bytes = {};
        repeat ($urandom_range(1, 24)) frame_bytes.push_back(8'($urandom));
        if ($urandom_range(0, 1) == 0) frame_bytes[0] = SYNC_FIRST;
      end
      default: ;
    endcase
  endtask

  initial begin
    int phase_start;
    int drain;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: lone byte, minimum clean frame, status with one payload byte, cut header
    program_all(8'h00, 8'hff, 8'h80, MAX_FRAME_RESET);
    frame_bytes = {8'hff};
    send_frame();
    frame_bytes = {SYNC_FIRST, SYNC_SECOND, ver_now, seq_now, cmd_now, 8'h00, 8'h00, 8'h00};
    seal_frame();
    send_frame();
    frame_bytes = {SYNC_FIRST, SYNC_SECOND, ver_now, seq_now, cmd_now, 8'hff, 8'h00, 8'h01,
                   8'h00};
    seal_frame();
    send_frame();
    frame_bytes = {SYNC_FIRST, SYNC_SECOND, 8'h00};
    send_frame();

    for (int phase = 0; phase < 6; phase++) begin
      settle();
      case (phase)
        0: program_all(8'h00, 8'h00, 8'h00, MAX_FRAME_RESET);
        1: program_all(8'hff, 8'hff, 8'hff, MIN_FRAME);
        2: program_all(8'($urandom), 8'($urandom), 8'($urandom),
                       COUNT_W'($urandom_range(10, 60)));
        3: program_all(8'($urandom), 8'($urandom), 8'($urandom),
                       COUNT_W'($urandom_range(10, 65545)));
        // below the shortest legal frame
        4: program_all(8'($urandom), 8'($urandom), 8'($urandom), COUNT_W'(9));
        default: program_all(8'($urandom), 8'($urandom), 8'($urandom),
                             COUNT_W'($urandom_range(30, 200)));
      endcase
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) begin
        if ($urandom_range(0, 3) == 0) begin
          settle();
          seq_now = 8'($urandom);
          write_reg(REG_SEQUENCE, CFG_DATA_W'(seq_now));
          cfg_write <= 1'b0;
        end
        idle_on <= (phase != 5) && ($urandom_range(0, 3) != 0);
        build_frame();
        send_frame();
      end
    end

    in_valid <= 1'b0;
    drain = 0;
    @(posedge clk);
    while (pending != 0 && drain < 2000) begin
      @(posedge clk);
      drain++;
    end
    repeat (8) @(posedge clk);
    if (pending != 0) $display("%0t: %0d expected results never arrived", $time, pending);

    $display("covered %0d frames (%0d bytes): directed frames plus six register settings",
             frames_sent, bytes_sent);
    $display("checked %0d forwarded payload bytes and %0d verdicts, %0d of them ok",
             n_forwarded, n_verdicts, n_ok);
    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
